// ===== rtl/ss_pkg.sv =====
// Shared constants and types for the stride scheduler.
package ss_pkg;

	localparam int NUM_CLIENTS = 4;
	localparam int CLIENT_W    = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int PASS_W      = 32;
	localparam int STRIDE_W    = 20;
	localparam int CFG_IDX_W   = 2;
	localparam int GRANT_W     = 2;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1);

	typedef logic [NUM_CLIENTS-1:0][PASS_W-1:0]   pass_vec_t;
	typedef logic [NUM_CLIENTS-1:0][STRIDE_W-1:0] stride_vec_t;

	typedef struct packed {
		logic [CLIENT_W-1:0] grant;
		logic [PASS_W-1:0]   pass_before;
		logic [PASS_W-1:0]   pass_after;
		logic                all_equal;
	} pick_t;

endpackage

// ===== rtl/ss_pick.sv =====
// Winner selection: modular minimum of pass values, stride add, equality check.
module ss_pick (
	input  ss_pkg::pass_vec_t   pass_values,
	input  ss_pkg::stride_vec_t strides,
	output ss_pkg::pick_t       pick
);

	always_comb begin
		logic [ss_pkg::CLIENT_W-1:0] best;
		logic [ss_pkg::PASS_W-1:0]   diff;
		logic [ss_pkg::PASS_W-1:0]   sum;
		ss_pkg::pass_vec_t           upd;
		logic                        eq;

		// scan upward, replace only when strictly behind (top bit of a - b)
		best = '0;
		for (int i = 1; i < ss_pkg::NUM_CLIENTS; i++) begin
			diff = pass_values[i] - pass_values[best];
			if (diff[ss_pkg::PASS_W-1]) begin
				best = ss_pkg::CLIENT_W'(i);
			end
		end

		sum = pass_values[best]
			+ {{(ss_pkg::PASS_W - ss_pkg::STRIDE_W){1'b0}}, strides[best]};

		upd = pass_values;
		upd[best] = sum;

		eq = 1'b1;
		for (int i = 1; i < ss_pkg::NUM_CLIENTS; i++) begin
			if (upd[i] != upd[0]) begin
				eq = 1'b0;
			end
		end

		pick.grant       = best;
		pick.pass_before = pass_values[best];
		pick.pass_after  = sum;
		pick.all_equal   = eq;
	end

endmodule

// ===== rtl/ss_pass_table.sv =====
// Per-client pass and stride registers.
module ss_pass_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [ss_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [ss_pkg::STRIDE_W-1:0]  wr_data,
	input  logic                         upd_en,
	input  ss_pkg::pick_t                pick,
	output ss_pkg::pass_vec_t            pass_values,
	output ss_pkg::stride_vec_t          strides
);

	ss_pkg::pass_vec_t   pass_q;
	ss_pkg::stride_vec_t stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0;
		end else if (upd_en) begin
			pass_q[pick.grant] <= pick.pass_after;
		end
	end

	// indexes past the client count are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ss_pkg::NUM_CLIENTS; i++) begin
				stride_q[i] <= ss_pkg::STRIDE_RESET;
			end
		end else if (wr_en && (int'(wr_index) < ss_pkg::NUM_CLIENTS)) begin
			stride_q[ss_pkg::CLIENT_W'(wr_index)] <= wr_data;
		end
	end

	assign pass_values = pass_q;
	assign strides     = stride_q;

endmodule

// ===== rtl/stride_scheduler.sv =====
// Stride scheduler top level: input stage, grant logic, result register.
//
//  channel  direction  handshake             payload
//  in       in         in_valid / in_ready   tick
//  out      out        out_valid / out_ready granted_client, pass_before, all_equal
//  cfg      in         wr_en                 wr_index, wr_data
//
// One word accepted per cycle while the result register is not stalled; a grant
// moves from the input stage into the result register when that stage advances. The pass
// update completes in the grant cycle, so back-to-back ticks see each other's result. A
// word with tick low retires with no result. Reset clears all passes to zero and sets
// every stride to one. A stalled result register holds one grant; the input stage fills behind it.
module stride_scheduler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         tick,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ss_pkg::GRANT_W-1:0]   granted_client,
	output logic [ss_pkg::PASS_W-1:0]    pass_before,
	output logic                         all_equal,
	input  logic                         wr_en,
	input  logic [ss_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [ss_pkg::STRIDE_W-1:0]  wr_data
);

	logic                         valid_s1;
	logic                         adv;
	logic                         out_valid_q;
	logic [ss_pkg::GRANT_W-1:0]   grant_q;
	logic [ss_pkg::PASS_W-1:0]    pass_before_q;
	logic                         all_equal_q;
	ss_pkg::pass_vec_t            pass_values;
	ss_pkg::stride_vec_t          strides;
	ss_pkg::pick_t                pick;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// only a word with tick set needs a grant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && tick;
		end
	end

	ss_pass_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.upd_en      (adv),
		.pick        (pick),
		.pass_values (pass_values),
		.strides     (strides)
	);

	ss_pick u_pick (
		.pass_values (pass_values),
		.strides     (strides),
		.pick        (pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grant_q       <= ss_pkg::GRANT_W'(pick.grant);
			pass_before_q <= pick.pass_before;
			all_equal_q   <= pick.all_equal;
		end
	end

	assign out_valid      = out_valid_q;
	assign granted_client = grant_q;
	assign pass_before    = pass_before_q;
	assign all_equal      = all_equal_q;

endmodule

// ===== bench/stride_scheduler_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the stride scheduler: directed and random ticks against a grant predictor.
module stride_scheduler_tb;

	typedef struct {
		bit [ss_pkg::GRANT_W-1:0] client;
		bit [ss_pkg::PASS_W-1:0]  prev_pass;
		bit                       level;
	} grant_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic                         tick;
	logic                         out_valid;
	logic                         out_ready;
	logic [ss_pkg::GRANT_W-1:0]   granted_client;
	logic [ss_pkg::PASS_W-1:0]    pass_before;
	logic                         all_equal;
	logic                         wr_en;
	logic [ss_pkg::CFG_IDX_W-1:0] wr_index;
	logic [ss_pkg::STRIDE_W-1:0]  wr_data;

	bit [ss_pkg::PASS_W-1:0]   client_pass [ss_pkg::NUM_CLIENTS];
	bit [ss_pkg::STRIDE_W-1:0] client_stride [ss_pkg::NUM_CLIENTS];
	grant_t                    grants_due [$];

	int  errors;
	int  grants_checked;
	int  stride_settings;
	bit  steady;

	stride_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.tick(tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted_client(granted_client),
		.pass_before(pass_before),
		.all_equal(all_equal),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_scheduler_state();
		for (int i = 0; i < ss_pkg::NUM_CLIENTS; i++) begin
			client_pass[i]   = '0;
			client_stride[i] = ss_pkg::STRIDE_RESET;
		end
	endfunction

	// smallest pass by modular difference, lowest index on ties
	function automatic void predict_grant();
		int                      best;
		bit [ss_pkg::PASS_W-1:0] diff;
		grant_t                  g;
		best = 0;
		for (int i = 1; i < ss_pkg::NUM_CLIENTS; i++) begin
			diff = client_pass[i] - client_pass[best];
			if (diff[ss_pkg::PASS_W-1])
				best = i;
		end
		g.client = ss_pkg::GRANT_W'(best);
		g.prev_pass = client_pass[best];
		client_pass[best] = client_pass[best] + ss_pkg::PASS_W'(client_stride[best]);
		g.level = 1'b1;
		for (int i = 1; i < ss_pkg::NUM_CLIENTS; i++)
			if (client_pass[i] != client_pass[0])
				g.level = 1'b0;
		grants_due.push_back(g);
	endfunction

	function automatic void check_grant();
		grant_t g;
		if (grants_due.size() == 0) begin
			$display("%0t: unexpected word: client %0d pass %0h all_equal %0b",
				$time, granted_client, pass_before, all_equal);
			errors++;
			return;
		end
		g = grants_due.pop_front();
		grants_checked++;
		if (granted_client !== g.client) begin
			$display("%0t: granted_client expected %0d got %0d",
				$time, g.client, granted_client);
			errors++;
		end
		if (pass_before !== g.prev_pass) begin
			$display("%0t: pass_before expected %0h got %0h",
				$time, g.prev_pass, pass_before);
			errors++;
		end
		if (all_equal !== g.level) begin
			$display("%0t: all_equal expected %0b got %0b", $time, g.level, all_equal);
			errors++;
		end
	endfunction

	// result side: random backpressure, check on every accepted word
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_grant();
			@(negedge clk);
			out_ready <= steady || ($urandom_range(99) >= 31);
		end
	end

	// entered and left at a falling edge; valid stays up between back-to-back words
	task automatic send_tick(input bit t);
		if (!steady) begin
			while ($urandom_range(99) < 31) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		tick     <= t;
		do @(posedge clk); while (!in_ready);
		if (t)
			predict_grant();
		@(negedge clk);
	endtask

	// wait out all grants, then wait for any idle word still in flight
	task automatic drain();
		in_valid <= 1'b0;
		while (grants_due.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic load_strides(input ss_pkg::stride_vec_t sv);
		for (int i = 0; i < ss_pkg::NUM_CLIENTS; i++) begin
			wr_en    <= 1'b1;
			wr_index <= ss_pkg::CFG_IDX_W'(i);
			wr_data  <= sv[i];
			client_stride[i] = sv[i];
			@(negedge clk);
		end
		wr_en <= 1'b0;
		stride_settings++;
	endtask

	function automatic bit [ss_pkg::STRIDE_W-1:0] pick_stride();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return '0;
		else if (r < 3)
			return '1;
		else if (r < 5)
			return ss_pkg::STRIDE_W'(1);
		else if (r < 12)
			// lcm of 1..12 over tickets
			return ss_pkg::STRIDE_W'(27720 / $urandom_range(1, 12));
		else
			return ss_pkg::STRIDE_W'($urandom_range(1, 20'hFFFFF));
	endfunction

	// reset strides of one: round robin, all passes level every fourth grant
	task automatic test_reset_grants();
		for (int i = 0; i < 9; i++)
			send_tick(i != 4);
	endtask

	// a zero stride is kept, so that client never advances and keeps winning
	task automatic test_zero_stride();
		ss_pkg::stride_vec_t sv;
		drain();
		sv[0] = ss_pkg::STRIDE_W'(5);
		sv[1] = '0;
		sv[2] = ss_pkg::STRIDE_W'(5);
		sv[3] = ss_pkg::STRIDE_W'(5);
		load_strides(sv);
		repeat (5) send_tick(1'b1);
	endtask

	task automatic test_extreme_strides();
		ss_pkg::stride_vec_t sv;
		drain();
		sv[0] = '1;
		sv[1] = ss_pkg::STRIDE_W'(20'h55555);
		sv[2] = ss_pkg::STRIDE_W'(20'hAAAAA);
		sv[3] = ss_pkg::STRIDE_W'(1);
		load_strides(sv);
		repeat (8) send_tick(1'b1);
	endtask

	task automatic test_random_traffic();
		ss_pkg::stride_vec_t sv;
		for (int p = 0; p < 10; p++) begin
			drain();
			for (int i = 0; i < ss_pkg::NUM_CLIENTS; i++)
				sv[i] = pick_stride();
			load_strides(sv);
			steady = (p == 0);
			repeat (170) send_tick($urandom_range(9) != 0);
		end
		steady = 1'b0;
	endtask

	// full-scale strides on every client: large pass steps
	task automatic test_full_scale_strides();
		ss_pkg::stride_vec_t sv;
		drain();
		for (int i = 0; i < ss_pkg::NUM_CLIENTS; i++)
			sv[i] = '1;
		load_strides(sv);
		repeat (200) send_tick(1'b1);
	endtask

	initial begin
		in_valid = 1'b0;
		tick     = 1'b0;
		wr_en    = 1'b0;
		wr_index = '0;
		wr_data  = '0;
		arst_n   = 1'b0;
		steady   = 1'b0;
		errors   = 0;
		grants_checked  = 0;
		stride_settings = 0;
		clear_scheduler_state();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_grants();
		test_zero_stride();
		test_extreme_strides();
		test_random_traffic();
		test_full_scale_strides();
		drain();

		$display("%0d grants checked over %0d stride settings, with idle ticks,",
			grants_checked, stride_settings);
		$display("zero and full-scale strides, ties and random backpressure");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#500_000;
		$display("Timeout with %0d grants outstanding", grants_due.size());
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ss_pkg.sv
rtl/ss_pick.sv
rtl/ss_pass_table.sv
rtl/stride_scheduler.sv
bench/stride_scheduler_tb.sv
